[rtl/core/fifo_fed_fm_iq_modulator_assert.svh]
// assertion macros for the fm modulator block
`ifndef FIFO_FED_FM_IQ_MODULATOR_ASSERT_SVH
`define FIFO_FED_FM_IQ_MODULATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FFIQM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fm modulator check failed");

// next-cycle implication, checked outside reset
`define FFIQM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fm modulator check failed");

`endif

[rtl/core/ffiqm_pkg.sv]
// shared types, constants and the sine table of the fm modulator
package ffiqm_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int GAIN_W    = 13;
    localparam int DEC_W     = 8;
    localparam int THR_W     = 12;
    localparam int PHASE_W   = 32;
    localparam int PREVIEW_W = 16;
    localparam int IQ_W      = 8;
    localparam int PROD_W    = BYTE_W + GAIN_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVIATION_GAIN   = 2'd0,
        CFG_DECIMATION_LIMIT = 2'd1,
        CFG_REFILL_THRESHOLD = 2'd2
    } t_cfg_index;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET = 13'd2000;
    localparam logic [DEC_W-1:0]  DEC_RESET  = 8'd31;
    localparam logic [THR_W-1:0]  THR_RESET  = 12'd3072;

    // phase format: one turn is 2^26, table index taken from the top bits of that
    localparam int TURN_MSB     = 25;
    localparam int SINE_ENTRIES = 256;
    localparam int LUT_W        = $clog2(SINE_ENTRIES);
    localparam logic [LUT_W-1:0] QUARTER_IDX = LUT_W'(SINE_ENTRIES / 4);

    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
    localparam logic [63:0] ENTRIES_64  = 64'(SINE_ENTRIES);

    typedef logic signed [IQ_W-1:0] t_sine_lut [SINE_ENTRIES];

    // fifo control and status between top and fifo
    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic signed [BYTE_W-1:0] wr_byte;
    } t_fifo_cmd;

    typedef struct packed {
        logic signed [BYTE_W-1:0] head;
        logic signed [BYTE_W-1:0] next;
        logic                     refill;
    } t_fifo_stat;

    // 127*sin(pi/2 * r/entries), truncated, taylor series in q31
    function automatic logic [IQ_W-1:0] quarter_value(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        if (r == 64'd0) begin
            return '0;
        end
        if (r >= ENTRIES_64) begin
            return IQ_W'(127);
        end
        x    = (HALF_PI_Q31 * r) / ENTRIES_64;
        x2   = (x * x) >> 31;
        term = x;
        sum  = x;
        term = ((term * x2) >> 31) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 31) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 31) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 31) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 31) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 31) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 31) / 64'd210;
        sum  = sum - term;
        term = ((term * x2) >> 31) / 64'd272;
        sum  = sum + term;
        scaled = (64'd127 * sum) >> 31;
        return scaled[IQ_W-1:0];
    endfunction

    // full-turn table built from quarter-wave values
    function automatic t_sine_lut build_sine_lut();
        t_sine_lut   lut;
        logic [63:0] u;
        logic [63:0] q;
        logic [63:0] r;
        logic [IQ_W-1:0] v;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            u = 64'(4 * k);
            q = u / ENTRIES_64;
            r = u % ENTRIES_64;
            if (q[0]) begin
                v = quarter_value(ENTRIES_64 - r);
            end else begin
                v = quarter_value(r);
            end
            if (q[1]) begin
                v = -v;
            end
            lut[k] = $signed(v);
        end
        return lut;
    endfunction

    localparam t_sine_lut SINE_LUT = build_sine_lut();

endpackage

[rtl/core/ffiqm_audio_fifo.sv]
// circular audio fifo with two registered read ports, fill tracking and refill logic
module ffiqm_audio_fifo #(
    parameter int FIFO_DEPTH = 4096,
    parameter int CHUNK_SIZE = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ffiqm_pkg::t_fifo_cmd               i_cmd,
    input  logic [ffiqm_pkg::THR_W-1:0]        i_refill_threshold,
    output ffiqm_pkg::t_fifo_stat              o_stat
);
    import ffiqm_pkg::*;

    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CHUNK_W = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;
    localparam int LVL_W   = (PTR_W > THR_W) ? PTR_W : THR_W;
    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [PTR_W:0]     DEPTH_EXT  = (PTR_W + 1)'(FIFO_DEPTH);
    localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNK_SIZE - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    logic [BYTE_W-1:0]  r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic               r_filled, n_filled;
    logic [CHUNK_W-1:0] r_chunk, n_chunk;
    logic               r_asked, n_asked;

    logic [PTR_W-1:0]   rd_plus1;
    logic [PTR_W-1:0]   rd_plus2;
    logic [PTR_W-1:0]   addr_a;
    logic [PTR_W-1:0]   addr_b;
    logic [PTR_W:0]     level_ext;
    logic [LVL_W-1:0]   level;
    logic               refill;

    // read port data and their zero/bypass qualifiers
    logic [BYTE_W-1:0]  r_qa, r_qb, r_wd;
    logic               r_za, r_zb, r_ba, r_bb;

    // pointer arithmetic and read addresses for the state after this beat
    always_comb begin
        rd_plus1 = ptr_inc(r_rd_ptr);
        rd_plus2 = ptr_inc(rd_plus1);
        addr_a   = i_cmd.pop ? rd_plus1 : r_rd_ptr;
        addr_b   = i_cmd.pop ? rd_plus2 : rd_plus1;
        if (r_wr_ptr >= rd_plus1) begin
            level_ext = {1'b0, r_wr_ptr} - {1'b0, rd_plus1};
        end else begin
            level_ext = {1'b0, r_wr_ptr} + DEPTH_EXT - {1'b0, rd_plus1};
        end
        level  = LVL_W'(level_ext[PTR_W-1:0]);
        refill = i_cmd.pop && (level < LVL_W'(i_refill_threshold)) && !r_asked;
    end

    // pointer, fill and chunk bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_filled = r_filled;
        n_chunk  = r_chunk;
        n_asked  = r_asked;
        if (i_cmd.push) begin
            n_wr_ptr = ptr_inc(r_wr_ptr);
            if (r_wr_ptr == PTR_LAST) begin
                n_filled = 1'b1;
            end
            if ((r_wr_ptr == PTR_LAST) || (r_chunk == CHUNK_LAST)) begin
                n_chunk = '0;
                n_asked = 1'b0;
            end else begin
                n_chunk = r_chunk + 1'b1;
            end
        end
        if (i_cmd.pop) begin
            n_rd_ptr = rd_plus1;
            if (refill) begin
                n_asked = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_filled <= 1'b0;
            r_chunk  <= '0;
            r_asked  <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_filled <= n_filled;
            r_chunk  <= n_chunk;
            r_asked  <= n_asked;
        end
    end

    // storage write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wr_ptr] <= i_cmd.wr_byte;
        end
    end

    // storage read ports, read-before-write
    always_ff @(posedge i_clk) begin
        r_qa <= r_mem[addr_a];
        r_qb <= r_mem[addr_b];
        r_wd <= i_cmd.wr_byte;
    end

    // never-written entries read as zero; same-edge writes are forwarded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_za <= 1'b1;
            r_zb <= 1'b1;
            r_ba <= 1'b0;
            r_bb <= 1'b0;
        end else begin
            r_za <= !(r_filled || (addr_a < r_wr_ptr));
            r_zb <= !(r_filled || (addr_b < r_wr_ptr));
            r_ba <= i_cmd.push && (r_wr_ptr == addr_a);
            r_bb <= i_cmd.push && (r_wr_ptr == addr_b);
        end
    end

    always_comb begin
        o_stat.head   = r_ba ? $signed(r_wd) : (r_za ? '0 : $signed(r_qa));
        o_stat.next   = r_bb ? $signed(r_wd) : (r_zb ? '0 : $signed(r_qb));
        o_stat.refill = refill;
    end

endmodule

[rtl/core/ffiqm_nco.sv]
// phase accumulator with sine/cosine table lookup
module ffiqm_nco (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_tick,
    input  logic signed [ffiqm_pkg::BYTE_W-1:0]    i_sample,
    input  logic [ffiqm_pkg::GAIN_W-1:0]           i_gain,
    output logic signed [ffiqm_pkg::IQ_W-1:0]      o_i,
    output logic signed [ffiqm_pkg::IQ_W-1:0]      o_q
);
    import ffiqm_pkg::*;

    logic [PHASE_W-1:0]       r_phase, n_phase;
    logic signed [PROD_W-1:0] prod;
    logic [PHASE_W-1:0]       step;
    logic [LUT_W-1:0]         idx_q;
    logic [LUT_W-1:0]         idx_i;

    // step = sample * 4 * gain, sign-extended to the accumulator width
    always_comb begin
        prod    = i_sample * $signed({1'b0, i_gain});
        step    = {{(PHASE_W - PROD_W - 2){prod[PROD_W-1]}}, prod, 2'b00};
        n_phase = r_phase + step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_tick) begin
            r_phase <= n_phase;
        end
    end

    // cosine is the sine a quarter turn ahead
    always_comb begin
        idx_q = n_phase[TURN_MSB -: LUT_W];
        idx_i = idx_q + QUARTER_IDX;
        o_q   = SINE_LUT[idx_q];
        o_i   = SINE_LUT[idx_i];
    end

endmodule

[rtl/core/fifo_fed_fm_iq_modulator.sv]
// fm i/q modulator top level: input register, decimation, config and result register
// Takes one beat per clock while no tick waits. A beat is either a push (audio byte
// into the 4096-entry circular fifo, no result) or a tick (one i/q result beat). Every
// beat is held in the input register and a tick's result is then registered in the
// result register; the sustained rate is one beat per clock while no tick waits. A tick
// waits only while the result register is full and stalled; pushes never wait. The
// fifo storage has one write port and two registered read ports (the byte at the read
// pointer and the one after it), which lets a pop and the phase update happen in the
// same cycle. Storage is not cleared after reset: entries never written read as zero
// through a fill tracker, so the block is ready right after reset. Every
// decimation_limit+1 ticks a tick pops the fifo, shows the popped byte on
// o_preview_sample and may raise o_refill_request once per refill chunk.
module fifo_fed_fm_iq_modulator #(
    parameter int FIFO_DEPTH = 4096,
    parameter int CHUNK_SIZE = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input channel
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic                                    i_opcode,
    input  logic signed [ffiqm_pkg::BYTE_W-1:0]     i_audio_byte,
    // result channel
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [ffiqm_pkg::IQ_W-1:0]       o_i_out,
    output logic signed [ffiqm_pkg::IQ_W-1:0]       o_q_out,
    output logic                                    o_preview_valid,
    output logic signed [ffiqm_pkg::PREVIEW_W-1:0]  o_preview_sample,
    output logic                                    o_refill_request,
    // configuration writes
    input  logic                                    i_cfg_we,
    input  logic [ffiqm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ffiqm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import ffiqm_pkg::*;

    // configuration registers
    logic [GAIN_W-1:0] r_gain;
    logic [DEC_W-1:0]  r_dec_limit;
    logic [THR_W-1:0]  r_threshold;

    // input register
    logic                     r_in_valid;
    logic                     r_in_op;
    logic signed [BYTE_W-1:0] r_in_byte;

    // decimation
    logic [DEC_W-1:0] r_dec_count, n_dec_count;

    // result register
    logic                        r_out_valid;
    logic signed [IQ_W-1:0]      r_out_i;
    logic signed [IQ_W-1:0]      r_out_q;
    logic                        r_out_pv;
    logic signed [PREVIEW_W-1:0] r_out_preview;
    logic                        r_out_refill;

    logic                     out_free;
    logic                     proceed;
    logic                     accept;
    logic                     tick;
    logic                     pop;
    logic signed [BYTE_W-1:0] sample;
    t_fifo_cmd                fifo_cmd;
    t_fifo_stat               fifo_stat;
    logic signed [IQ_W-1:0]   nco_i;
    logic signed [IQ_W-1:0]   nco_q;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RESET;
            r_dec_limit <= DEC_RESET;
            r_threshold <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEVIATION_GAIN:   r_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_DECIMATION_LIMIT: r_dec_limit <= i_cfg_data[DEC_W-1:0];
                CFG_REFILL_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: pushes always move on, ticks need room in the result register
    always_comb begin
        out_free = !r_out_valid || !i_stall;
        tick     = (r_in_op == OP_TICK);
        proceed  = r_in_valid && (!tick || out_free);
        o_stall  = r_in_valid && !proceed;
        accept   = i_valid && !o_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_op   <= i_opcode;
            r_in_byte <= i_audio_byte;
        end
    end

    // decimation counter decides the pop
    always_comb begin
        pop         = proceed && tick && (r_dec_count >= r_dec_limit);
        n_dec_count = r_dec_count;
        if (proceed && tick) begin
            n_dec_count = pop ? '0 : r_dec_count + 1'b1;
        end
        fifo_cmd.push    = proceed && !tick;
        fifo_cmd.pop     = pop;
        fifo_cmd.wr_byte = r_in_byte;
        sample           = pop ? fifo_stat.next : fifo_stat.head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_count <= '0;
        end else begin
            r_dec_count <= n_dec_count;
        end
    end

    ffiqm_audio_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .CHUNK_SIZE (CHUNK_SIZE)
    ) u_fifo (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (fifo_cmd),
        .i_refill_threshold (r_threshold),
        .o_stat             (fifo_stat)
    );

    ffiqm_nco u_nco (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (proceed && tick),
        .i_sample (sample),
        .i_gain   (r_gain),
        .o_i      (nco_i),
        .o_q      (nco_q)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && tick) begin
            r_out_i       <= nco_i;
            r_out_q       <= nco_q;
            r_out_pv      <= pop;
            r_out_preview <= pop ? {fifo_stat.head, 8'h00} : '0;
            r_out_refill  <= fifo_stat.refill;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_i_out          = r_out_i;
    assign o_q_out          = r_out_q;
    assign o_preview_valid  = r_out_pv;
    assign o_preview_sample = r_out_preview;
    assign o_refill_request = r_out_refill;

    // checks
    `include "fifo_fed_fm_iq_modulator_assert.svh"

    `FFIQM_ASSERT_NOW(a_push_never_waits, i_clk, i_rst_n, r_in_valid && (r_in_op == OP_PUSH), !o_stall)
    `FFIQM_ASSERT_NOW(a_refill_on_pop, i_clk, i_rst_n, r_out_valid && r_out_refill, r_out_pv)
    `FFIQM_ASSERT_NOW(a_idle_preview_zero, i_clk, i_rst_n, r_out_valid && !r_out_pv, r_out_preview == '0)
    `FFIQM_ASSERT_NEXT(a_pop_clears_count, i_clk, i_rst_n, pop, r_dec_count == '0)

endmodule

[tb/tb_fifo_fed_fm_iq_modulator.sv]
// self-checking testbench for the fifo fed fm i/q modulator
`timescale 1ns / 100ps

module tb_fifo_fed_fm_iq_modulator;

    import ffiqm_pkg::*;

    localparam int          FIFO_BYTES   = 4096;
    localparam int          CHUNK_BYTES  = 1024;
    localparam int          ROM_ENTRIES  = 256;
    localparam logic [63:0] HALF_PI_FIX  = 64'd3373259426;
    localparam logic [31:0] QUARTER_TURN = 32'h0100_0000;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          CYCLE_LIMIT  = 400000;

    // one expected result beat
    typedef struct {
        logic signed [7:0]  i_val;
        logic signed [7:0]  q_val;
        logic               pv;
        logic signed [15:0] ps;
        logic               rr;
    } t_iq_beat;

    // dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_opcode = OP_TICK;
    logic signed [7:0]     i_audio_byte = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic signed [7:0]     o_i_out;
    logic signed [7:0]     o_q_out;
    logic                  o_preview_valid;
    logic signed [15:0]    o_preview_sample;
    logic                  o_refill_request;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor state
    logic signed [7:0] sine_rom [ROM_ENTRIES];
    logic [7:0]        audio_fifo_mem [FIFO_BYTES];
    logic [11:0]       wr_ptr;
    logic [11:0]       rd_ptr;
    logic              refill_pending;
    logic [7:0]        tick_count;
    logic [31:0]       phase_acc;
    logic [12:0]       dev_gain;
    logic [7:0]        dec_limit;
    logic [11:0]       refill_thr;

    t_iq_beat iq_expected [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;

    fifo_fed_fm_iq_modulator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_audio_byte     (i_audio_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_i_out          (o_i_out),
        .o_q_out          (o_q_out),
        .o_preview_valid  (o_preview_valid),
        .o_preview_sample (o_preview_sample),
        .o_refill_request (o_refill_request),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // 127*sin(pi/2 * r/256) truncated, q31 taylor series
    function automatic logic [7:0] quarter_wave(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        if (r == 64'd0) begin
            return 8'd0;
        end
        if (r >= 64'(ROM_ENTRIES)) begin
            return 8'd127;
        end
        x    = (HALF_PI_FIX * r) / 64'(ROM_ENTRIES);
        x2   = (x * x) >> 31;
        term = x;
        acc  = x;
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 31) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        acc = (64'd127 * acc) >> 31;
        return acc[7:0];
    endfunction

    // predictor: apply one accepted beat, queue the result a tick makes
    task automatic advance_modulator(input t_opcode op, input logic [7:0] b);
        t_iq_beat    res;
        logic [11:0] level;
        logic [31:0] cos_phase;
        int          aud_val;
        int          step;
        if (op == OP_PUSH) begin
            audio_fifo_mem[wr_ptr] = b;
            wr_ptr = wr_ptr + 12'd1;
            // chunk complete re-arms the refill request
            if (wr_ptr % CHUNK_BYTES == 0) begin
                refill_pending = 1'b0;
            end
        end else begin
            res.pv = 1'b0;
            res.ps = '0;
            res.rr = 1'b0;
            // pop once the tick count reaches the limit
            if (tick_count >= dec_limit) begin
                tick_count = '0;
                res.pv = 1'b1;
                res.ps = {audio_fifo_mem[rd_ptr], 8'h00};
                rd_ptr = rd_ptr + 12'd1;
                level = wr_ptr - rd_ptr;
                if (level < refill_thr && !refill_pending) begin
                    refill_pending = 1'b1;
                    res.rr = 1'b1;
                end
            end else begin
                tick_count = tick_count + 8'd1;
            end
            // phase step from the byte now at the read pointer
            aud_val = $signed(audio_fifo_mem[rd_ptr]);
            step = aud_val * 4 * int'(dev_gain);
            phase_acc = phase_acc + 32'(step);
            cos_phase = phase_acc + QUARTER_TURN;
            res.i_val = sine_rom[cos_phase[25:18]];
            res.q_val = sine_rom[phase_acc[25:18]];
            iq_expected.push_back(res);
        end
    endtask

    // send one beat with random sender gaps
    task automatic send_beat(input t_opcode op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_opcode     <= op;
        i_audio_byte <= b;
        i_valid      <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        advance_modulator(op, b);
    endtask

    // hold the sender until every result has arrived and the pipe is empty
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (iq_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all three registers while idle
    task automatic apply_settings(input logic [12:0] gain, input logic [7:0] lim,
                                  input logic [11:0] thr);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEVIATION_GAIN;
        i_cfg_data  <= gain;
        @(posedge i_clk);
        dev_gain = gain;
        i_cfg_index <= CFG_DECIMATION_LIMIT;
        i_cfg_data  <= 13'(lim);
        @(posedge i_clk);
        dec_limit = lim;
        i_cfg_index <= CFG_REFILL_THRESHOLD;
        i_cfg_data  <= 13'(thr);
        @(posedge i_clk);
        refill_thr = thr;
        i_cfg_we <= 1'b0;
    endtask

    // field extremes, every opcode, refill, underflow, lowered limit
    task automatic test_directed_edges();
        send_idle_pct  = 17;
        recv_stall_pct = 88;
        // ticks at reset settings, empty fifo
        repeat (3) send_beat(OP_TICK, 8'h00);
        // every tick pops: extremes of the byte, then underflow into never-written entries
        apply_settings(13'd8191, 8'd0, 12'd4095);
        send_beat(OP_PUSH, 8'h80);
        send_beat(OP_PUSH, 8'h7F);
        send_beat(OP_PUSH, 8'h00);
        send_beat(OP_PUSH, 8'hFF);
        send_beat(OP_PUSH, 8'h01);
        repeat (6) send_beat(OP_TICK, 8'hAA);
        // zero gain holds the phase
        apply_settings(13'd0, 8'd0, 12'd4095);
        repeat (2) send_beat(OP_TICK, 8'h55);
        // long limit, then lowered below the running count
        apply_settings(13'd4095, 8'd255, 12'd0);
        repeat (6) send_beat(OP_TICK, 8'h00);
        apply_settings(13'd4095, 8'd3, 12'd0);
        repeat (2) send_beat(OP_TICK, 8'h00);
    endtask

    // random traffic in four setting phases with the given idling
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        logic [12:0] gain;
        logic [7:0]  lim;
        logic [11:0] thr;
        int          push_pct;
        t_opcode     op;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int ph = 0; ph < 4; ph++) begin
            case ($urandom_range(3))
                0: gain = 13'd0;
                1: gain = 13'd8191;
                default: gain = 13'($urandom_range(8191));
            endcase
            case ($urandom_range(4))
                0: lim = 8'd0;
                1: lim = 8'd255;
                default: lim = 8'($urandom_range(7));
            endcase
            case ($urandom_range(3))
                0: thr = 12'd0;
                1: thr = 12'd4095;
                default: thr = 12'($urandom_range(4095));
            endcase
            apply_settings(gain, lim, thr);
            case ($urandom_range(3))
                0: push_pct = 15;
                1: push_pct = 40;
                2: push_pct = 60;
                default: push_pct = 85;
            endcase
            for (int n = 0; n < n_items / 4; n++) begin
                if ($urandom_range(99) == 0) begin
                    wait_drained();
                end
                op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_TICK;
                send_beat(op, 8'($urandom_range(255)));
            end
        end
    endtask

    // burst of pushes, then back-to-back pops through half of it
    task automatic test_fifo_wrap();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_settings(13'($urandom_range(8191)), 8'd0, 12'd2048);
        repeat (200) send_beat(OP_PUSH, 8'($urandom_range(255)));
        repeat (100) send_beat(OP_TICK, 8'($urandom_range(255)));
    endtask

    // result check against the oldest expectation, then next receiver stall
    always @(posedge i_clk) begin
        t_iq_beat e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (iq_expected.size() == 0) begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end else begin
                e = iq_expected.pop_front();
                if (o_i_out !== e.i_val) begin
                    $error("i_out expected %0d got %0d", e.i_val, o_i_out);
                    fail_count++;
                end
                if (o_q_out !== e.q_val) begin
                    $error("q_out expected %0d got %0d", e.q_val, o_q_out);
                    fail_count++;
                end
                if (o_preview_valid !== e.pv) begin
                    $error("preview_valid expected %0d got %0d", e.pv, o_preview_valid);
                    fail_count++;
                end
                if (o_preview_sample !== e.ps) begin
                    $error("preview_sample expected %0d got %0d", e.ps, o_preview_sample);
                    fail_count++;
                end
                if (o_refill_request !== e.rr) begin
                    $error("refill_request expected %0d got %0d", e.rr, o_refill_request);
                    fail_count++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // test sequence
    initial begin
        logic [63:0] u;
        logic [63:0] q;
        logic [63:0] r;
        logic [7:0]  v;
        // full-turn sine table from quarter-wave values
        for (int k = 0; k < ROM_ENTRIES; k++) begin
            u = 64'(4 * k);
            q = u / 64'(ROM_ENTRIES);
            r = u % 64'(ROM_ENTRIES);
            if (q[0]) begin
                v = quarter_wave(64'(ROM_ENTRIES) - r);
            end else begin
                v = quarter_wave(r);
            end
            if (q[1]) begin
                v = -v;
            end
            sine_rom[k] = $signed(v);
        end
        // predictor reset state
        for (int k = 0; k < FIFO_BYTES; k++) begin
            audio_fifo_mem[k] = 8'h00;
        end
        wr_ptr         = '0;
        rd_ptr         = '0;
        refill_pending = 1'b0;
        tick_count     = '0;
        phase_acc      = '0;
        dev_gain       = 13'd2000;
        dec_limit      = 8'd31;
        refill_thr     = 12'd3072;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_random_traffic(17, 88, 200);
        test_random_traffic(88, 17, 200);
        test_fifo_wrap();
        test_random_traffic(0, 0, 200);
        wait_drained();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/ffiqm_pkg.sv
rtl/core/ffiqm_audio_fifo.sv
rtl/core/ffiqm_nco.sv
rtl/core/fifo_fed_fm_iq_modulator.sv
tb/tb_fifo_fed_fm_iq_modulator.sv
